// ===== src/csem_pkg.sv =====
`timescale 1ns / 1ps

package csem_pkg;

    localparam int SEM_W      = 4;
    localparam int NUM_SEMS   = 1 << SEM_W;
    localparam int WAIT_W     = 4;
    localparam int WAIT_DEPTH = 1 << WAIT_W;
    localparam int PID_W      = 5;
    localparam int CNT_W      = 8;
    localparam int FUNC_W     = 2;
    localparam int QADDR_W    = SEM_W + WAIT_W;
    localparam int QDEPTH     = 1 << QADDR_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_WAIT  = 2'd1,
        OP_POST  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFREE   = 2'd1,
        ST_BLOCKED  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SEM_W-1:0]  sid;
        logic [PID_W-1:0]  pid;
        logic [CNT_W-1:0]  init;
    } t_req;

    // Per-semaphore state: count, queue read position, queue occupancy.
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [WAIT_W-1:0] head;
        logic [WAIT_W:0]   len;
    } t_sem_entry;

    typedef struct packed {
        logic             en;
        logic [SEM_W-1:0] sid;
        t_sem_entry       ent;
    } t_sem_upd;

    typedef struct packed {
        logic               en;
        logic [QADDR_W-1:0] addr;
        logic [PID_W-1:0]   pid;
    } t_q_wr;

    typedef struct packed {
        t_sem_upd sem;
        t_q_wr    wr;
    } t_exec_upd;

    typedef struct packed {
        t_status          status;
        logic [SEM_W-1:0] alloc_id;
        logic             wvalid;
        logic [PID_W-1:0] wpid;
    } t_result;

endpackage

// ===== src/csem_store.sv =====
`timescale 1ns / 1ps

module csem_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [csem_pkg::SEM_W-1:0]    i_rd_sid,
    input  csem_pkg::t_exec_upd           i_upd,
    output csem_pkg::t_sem_entry          o_ent,
    output logic [csem_pkg::PID_W-1:0]    o_wpid
);

    logic [csem_pkg::CNT_W-1:0]  r_cnt  [csem_pkg::NUM_SEMS];
    logic [csem_pkg::WAIT_W-1:0] r_head [csem_pkg::NUM_SEMS];
    logic [csem_pkg::WAIT_W:0]   r_len  [csem_pkg::NUM_SEMS];

    // Wait queues of all semaphores, one row of WAIT_DEPTH slots per semaphore.
    logic [csem_pkg::PID_W-1:0]  r_mem  [csem_pkg::QDEPTH];

    csem_pkg::t_sem_entry        r_ent;
    logic [csem_pkg::PID_W-1:0]  r_rd_pid;
    logic                        r_byp;
    logic [csem_pkg::PID_W-1:0]  r_byp_pid;

    csem_pkg::t_sem_entry        fwd;
    logic [csem_pkg::QADDR_W-1:0] rd_addr;
    logic                        hit;
    logic                        byp;

    // The update being committed in this cycle is forwarded so the lookup
    // always sees the state as it stands after the previous request.
    always_comb begin
        hit = i_upd.sem.en && (i_upd.sem.sid == i_rd_sid);
        if (hit) begin
            fwd = i_upd.sem.ent;
        end else begin
            fwd.cnt  = r_cnt[i_rd_sid];
            fwd.head = r_head[i_rd_sid];
            fwd.len  = r_len[i_rd_sid];
        end
        rd_addr = {i_rd_sid, fwd.head};
        byp     = i_upd.wr.en && (i_upd.wr.addr == rd_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < csem_pkg::NUM_SEMS; i++) begin
                r_cnt[i]  <= '0;
                r_head[i] <= '0;
                r_len[i]  <= '0;
            end
        end else if (i_upd.sem.en) begin
            r_cnt[i_upd.sem.sid]  <= i_upd.sem.ent.cnt;
            r_head[i_upd.sem.sid] <= i_upd.sem.ent.head;
            r_len[i_upd.sem.sid]  <= i_upd.sem.ent.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.wr.en) begin
            r_mem[i_upd.wr.addr] <= i_upd.wr.pid;
        end
        if (i_rd_en) begin
            r_ent     <= fwd;
            r_rd_pid  <= r_mem[rd_addr];
            r_byp     <= byp;
            r_byp_pid <= i_upd.wr.pid;
        end
    end

    assign o_ent  = r_ent;
    assign o_wpid = r_byp ? r_byp_pid : r_rd_pid;

endmodule

// ===== src/csem_exec.sv =====
`timescale 1ns / 1ps

module csem_exec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  csem_pkg::t_req                i_req,
    input  csem_pkg::t_sem_entry          i_ent,
    input  logic [csem_pkg::PID_W-1:0]    i_wpid,
    output csem_pkg::t_result             o_res,
    output csem_pkg::t_exec_upd           o_upd
);

    // Ids are handed out in order and never returned, so the free pool
    // reduces to a count of the ids granted so far.
    logic [csem_pkg::SEM_W:0] r_used;
    logic [csem_pkg::SEM_W:0] n_used;

    csem_pkg::t_result        res;
    csem_pkg::t_exec_upd      upd;
    logic                     used_inc;

    always_comb begin
        res          = '0;
        res.status   = csem_pkg::ST_OK;
        upd          = '0;
        upd.sem.sid  = i_req.sid;
        upd.sem.ent  = i_ent;
        upd.wr.pid   = i_req.pid;
        upd.wr.addr  = {i_req.sid, i_ent.head + i_ent.len[csem_pkg::WAIT_W-1:0]};
        used_inc     = 1'b0;

        case (i_req.func)
            csem_pkg::OP_ALLOC: begin
                if (r_used == (csem_pkg::SEM_W+1)'(csem_pkg::NUM_SEMS)) begin
                    res.status = csem_pkg::ST_NOFREE;
                end else begin
                    used_inc         = 1'b1;
                    res.alloc_id     = r_used[csem_pkg::SEM_W-1:0];
                    upd.sem.en       = 1'b1;
                    upd.sem.sid      = r_used[csem_pkg::SEM_W-1:0];
                    upd.sem.ent.cnt  = i_req.init;
                    upd.sem.ent.head = '0;
                    upd.sem.ent.len  = '0;
                end
            end
            csem_pkg::OP_WAIT: begin
                if (i_ent.cnt != '0) begin
                    upd.sem.en      = 1'b1;
                    upd.sem.ent.cnt = i_ent.cnt - 1'b1;
                end else if (i_ent.len >= (csem_pkg::WAIT_W+1)'(csem_pkg::WAIT_DEPTH)) begin
                    res.status = csem_pkg::ST_OVERFLOW;
                end else begin
                    res.status      = csem_pkg::ST_BLOCKED;
                    upd.wr.en       = 1'b1;
                    upd.sem.en      = 1'b1;
                    upd.sem.ent.len = i_ent.len + 1'b1;
                end
            end
            csem_pkg::OP_POST: begin
                if (i_ent.len != '0) begin
                    res.wvalid       = 1'b1;
                    res.wpid         = i_wpid;
                    upd.sem.en       = 1'b1;
                    upd.sem.ent.head = i_ent.head + 1'b1;
                    upd.sem.ent.len  = i_ent.len - 1'b1;
                end else if (i_ent.cnt != csem_pkg::CNT_MAX) begin
                    upd.sem.en      = 1'b1;
                    upd.sem.ent.cnt = i_ent.cnt + 1'b1;
                end
            end
            default: begin
            end
        endcase

        upd.sem.en = upd.sem.en && i_fire;
        upd.wr.en  = upd.wr.en && i_fire;
        n_used     = (i_fire && used_inc) ? r_used + 1'b1 : r_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    assign o_res = res;
    assign o_upd = upd;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (csem_pkg::SEM_W+1)'(csem_pkg::NUM_SEMS))
        else $error("more semaphores granted than exist");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd.sem.en |-> upd.sem.ent.len <= (csem_pkg::WAIT_W+1)'(csem_pkg::WAIT_DEPTH))
        else $error("wait queue occupancy beyond its depth");

    a_qwr_only_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd.wr.en |-> (res.status == csem_pkg::ST_BLOCKED))
        else $error("queue written by a request that did not block");

endmodule

// ===== src/counting_semaphore_engine.sv =====
`timescale 1ns / 1ps

// Counting semaphore engine: a pool of semaphores, each with a FIFO wait queue.
// Request channel: i_in_valid / o_in_stall with i_func, i_sem_id, i_caller_pid
// and i_init_count. A transfer happens at a rising edge where valid is high and
// stall is low. Every request transfer produces exactly one result transfer on
// o_out_valid / i_out_stall carrying o_status, o_alloc_id, o_woken_valid and
// o_woken_pid, in request order.
// The edge that takes a request looks up the addressed semaphore (count, queue
// position, head waiter from the queue memory) into the execute stage, which
// commits the update and loads the result register as it fires. Throughput is
// one request per cycle unless stalled; the lookup forwards the update
// committed in the same cycle, so back-to-back requests to one semaphore work.
// Allocate grants ids 0, 1, 2, ... in order and fails once all are granted.
// Reset (synchronous, active low) empties the pipeline, zeroes every count and
// queue, and makes all ids free again; the queue memory itself is not cleared,
// as only slots written by a blocking wait are ever read.
// When the receiver stalls, the result register holds its transfer, the
// execute stage keeps its request, and o_in_stall rises once both are full.

module counting_semaphore_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [csem_pkg::FUNC_W-1:0]   i_func,
    input  logic [csem_pkg::SEM_W-1:0]    i_sem_id,
    input  logic [csem_pkg::PID_W-1:0]    i_caller_pid,
    input  logic [csem_pkg::CNT_W-1:0]    i_init_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [csem_pkg::SEM_W-1:0]    o_alloc_id,
    output logic                          o_woken_valid,
    output logic [csem_pkg::PID_W-1:0]    o_woken_pid
);

    // Execute stage: the request taken in the previous transfer.
    csem_pkg::t_req       r_req;
    logic                 r_req_valid;
    logic                 n_req_valid;

    // Result register.
    csem_pkg::t_result    r_res;
    logic                 r_out_valid;
    logic                 n_out_valid;

    logic                 in_acc;
    logic                 exec_fire;
    csem_pkg::t_sem_entry ent;
    logic [csem_pkg::PID_W-1:0] wpid;
    csem_pkg::t_result    res;
    csem_pkg::t_exec_upd  upd;

    // The execute stage commits whenever the result register is free or is
    // being emptied in this cycle.
    assign exec_fire  = r_req_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_req_valid && !exec_fire;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_req_valid = r_req_valid;
        if (in_acc) begin
            n_req_valid = 1'b1;
        end else if (exec_fire) begin
            n_req_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (exec_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_req_valid <= n_req_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req.func <= i_func;
            r_req.sid  <= i_sem_id;
            r_req.pid  <= i_caller_pid;
            r_req.init <= i_init_count;
        end
        if (exec_fire) begin
            r_res <= res;
        end
    end

    csem_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_acc),
        .i_rd_sid (i_sem_id),
        .i_upd    (upd),
        .o_ent    (ent),
        .o_wpid   (wpid)
    );

    csem_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (exec_fire),
        .i_req   (r_req),
        .i_ent   (ent),
        .i_wpid  (wpid),
        .o_res   (res),
        .o_upd   (upd)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_res.status;
    assign o_alloc_id    = r_res.alloc_id;
    assign o_woken_valid = r_res.wvalid;
    assign o_woken_pid   = r_res.wpid;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("request stall without a held result");

    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> r_out_valid)
        else $error("committed request produced no result");

endmodule

// ===== test/tb_counting_semaphore_engine.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the counting semaphore engine. A behavioral copy of the
// semaphore pool predicts one result per accepted request; the results coming out
// of the engine are compared field by field, in order, against those predictions.
module tb_counting_semaphore_engine;

    // The request encoding leaves func 3 unused; the engine must treat it as a no-op.
    localparam logic [csem_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;

    localparam int NUM_ROUNDS    = 7;
    localparam int ROUND_ITEMS   = 100;
    localparam int MAX_REPORTED  = 10;
    localparam int DRAIN_CYCLES  = 8;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } t_stall_mode;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_stall;
    logic [csem_pkg::FUNC_W-1:0]   i_func       = '0;
    logic [csem_pkg::SEM_W-1:0]    i_sem_id     = '0;
    logic [csem_pkg::PID_W-1:0]    i_caller_pid = '0;
    logic [csem_pkg::CNT_W-1:0]    i_init_count = '0;
    logic                          o_out_valid;
    logic                          i_out_stall  = 1'b0;
    logic [1:0]                    o_status;
    logic [csem_pkg::SEM_W-1:0]    o_alloc_id;
    logic                          o_woken_valid;
    logic [csem_pkg::PID_W-1:0]    o_woken_pid;

    counting_semaphore_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_sem_id      (i_sem_id),
        .i_caller_pid  (i_caller_pid),
        .i_init_count  (i_init_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_alloc_id    (o_alloc_id),
        .o_woken_valid (o_woken_valid),
        .o_woken_pid   (o_woken_pid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the semaphore pool. It is updated at the edge where a request
    // transfer is taken, so it always reflects every request accepted so far.
    logic [csem_pkg::CNT_W-1:0]  sem_cnt    [csem_pkg::NUM_SEMS];
    logic [csem_pkg::PID_W-1:0]  waiter_mem [csem_pkg::QDEPTH];
    logic [csem_pkg::WAIT_W-1:0] waiter_head[csem_pkg::NUM_SEMS];
    logic [csem_pkg::WAIT_W:0]   waiter_len [csem_pkg::NUM_SEMS];
    logic [csem_pkg::SEM_W-1:0]  free_ids   [csem_pkg::NUM_SEMS];
    logic [csem_pkg::SEM_W-1:0]  free_head;
    logic [csem_pkg::SEM_W:0]    free_len;

    csem_pkg::t_result expected_results[$];

    // Event tallies, reported in the closing summary.
    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int n_granted     = 0;
    int n_nofree      = 0;
    int n_blocked     = 0;
    int n_overflow    = 0;
    int n_woken       = 0;
    int n_saturated   = 0;

    // Idling controls shared by the request driver and the stall generator.
    int          gap_max    = 0;
    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_run  = 0;
    logic        stall_hold = 1'b0;

    initial begin
        for (int i = 0; i < csem_pkg::NUM_SEMS; i++) begin
            sem_cnt[i]     = '0;
            waiter_head[i] = '0;
            waiter_len[i]  = '0;
            free_ids[i]    = (csem_pkg::SEM_W)'(i);
        end
        for (int i = 0; i < csem_pkg::QDEPTH; i++) begin
            waiter_mem[i] = '0;
        end
        free_head = '0;
        free_len  = (csem_pkg::SEM_W + 1)'(csem_pkg::NUM_SEMS);
    end

    // Applies one request to the shadow pool and returns the result it must produce.
    function automatic csem_pkg::t_result apply_request(
        input logic [csem_pkg::FUNC_W-1:0] func,
        input logic [csem_pkg::SEM_W-1:0]  sid,
        input logic [csem_pkg::PID_W-1:0]  pid,
        input logic [csem_pkg::CNT_W-1:0]  init);
        csem_pkg::t_result            res;
        logic [csem_pkg::SEM_W-1:0]   id;
        logic [csem_pkg::WAIT_W-1:0]  tail;
        logic [csem_pkg::QADDR_W-1:0] slot;
        res.status   = csem_pkg::ST_OK;
        res.alloc_id = '0;
        res.wvalid   = 1'b0;
        res.wpid     = '0;
        if (func == csem_pkg::OP_ALLOC) begin
            // Ids are handed out once and never returned, so the pool only drains.
            if (free_len == 0) begin
                res.status = csem_pkg::ST_NOFREE;
                n_nofree++;
            end else begin
                id              = free_ids[free_head];
                free_head       = free_head + 1'b1;
                free_len        = free_len - 1'b1;
                sem_cnt[id]     = init;
                waiter_head[id] = '0;
                waiter_len[id]  = '0;
                res.alloc_id    = id;
                n_granted++;
            end
        end else if (func == csem_pkg::OP_WAIT) begin
            if (sem_cnt[sid] != 0) begin
                sem_cnt[sid] = sem_cnt[sid] - 1'b1;
            end else if (waiter_len[sid] == csem_pkg::WAIT_DEPTH) begin
                res.status = csem_pkg::ST_OVERFLOW;
                n_overflow++;
            end else begin
                // The tail slot wraps within this semaphore's own queue region.
                tail             = waiter_head[sid] + waiter_len[sid][csem_pkg::WAIT_W-1:0];
                slot             = {sid, tail};
                waiter_mem[slot] = pid;
                waiter_len[sid]  = waiter_len[sid] + 1'b1;
                res.status       = csem_pkg::ST_BLOCKED;
                n_blocked++;
            end
        end else if (func == csem_pkg::OP_POST) begin
            if (waiter_len[sid] != 0) begin
                res.wvalid       = 1'b1;
                res.wpid         = waiter_mem[{sid, waiter_head[sid]}];
                waiter_head[sid] = waiter_head[sid] + 1'b1;
                waiter_len[sid]  = waiter_len[sid] - 1'b1;
                n_woken++;
            end else if (sem_cnt[sid] != csem_pkg::CNT_MAX) begin
                sem_cnt[sid] = sem_cnt[sid] + 1'b1;
            end else begin
                n_saturated++;
            end
        end
        return res;
    endfunction

    // Drives one request and returns at the edge where its transfer takes place.
    // Valid is left high on return, so the next call can follow back to back; a
    // gap at the start of a new burst is the only place where valid is lowered.
    task automatic send_request(input logic [csem_pkg::FUNC_W-1:0] func,
                                input logic [csem_pkg::SEM_W-1:0]  sid,
                                input logic [csem_pkg::PID_W-1:0]  pid,
                                input logic [csem_pkg::CNT_W-1:0]  init);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_sem_id     <= sid;
        i_caller_pid <= pid;
        i_init_count <= init;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(apply_request(func, sid, pid, init));
        items_sent++;
    endtask

    // The receiver stalls on a pattern of its own, chosen per test: never, on
    // independent random cycles, or in runs of random length.
    always @(negedge i_clk) begin
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_out_stall <= ($urandom_range(0, 99) < 30);
            end
            default: begin
                if (stall_run == 0) begin
                    stall_hold = !stall_hold;
                    stall_run  = stall_hold ? $urandom_range(1, 8) : $urandom_range(1, 12);
                end
                stall_run--;
                i_out_stall <= stall_hold;
            end
        endcase
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
                $display("%0t: result %0d field %s expected %0d got %0d",
                         $realtime, results_seen, name, want, got);
            end
        end
    endfunction

    // Every result transfer is matched against the oldest outstanding prediction.
    always @(posedge i_clk) begin : result_check
        csem_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED) begin
                    $display("%0t: result transfer with no request outstanding", $realtime);
                end
            end else begin
                want = expected_results.pop_front();
                check_field("status", 8'(want.status), 8'(o_status));
                check_field("alloc_id", 8'(want.alloc_id), 8'(o_alloc_id));
                check_field("woken_valid", 8'(want.wvalid), 8'(o_woken_valid));
                check_field("woken_pid", 8'(want.wpid), 8'(o_woken_pid));
            end
            results_seen++;
        end
    end

    // Wait and post on a semaphore that was never allocated: the count rises from
    // zero, blocked callers queue up and are released oldest first. Func 3 must be
    // ignored even with every other field at its top value.
    task automatic test_wait_post;
        send_request(FUNC_NOP, 4'd15, 5'd31, 8'd255);
        send_request(csem_pkg::OP_POST, 4'd15, 5'd0, 8'd0);
        send_request(csem_pkg::OP_WAIT, 4'd15, 5'd0, 8'd0);
        send_request(csem_pkg::OP_WAIT, 4'd15, 5'd31, 8'd0);
        send_request(csem_pkg::OP_WAIT, 4'd15, 5'd0, 8'd255);
        send_request(csem_pkg::OP_POST, 4'd15, 5'd10, 8'd0);
        send_request(csem_pkg::OP_POST, 4'd15, 5'd21, 8'd0);
        send_request(csem_pkg::OP_POST, 4'd15, 5'd0, 8'd0);
    endtask

    // Allocation hands out ids in order. A count allocated at its maximum stays
    // there on a post, and allocating a semaphore drops any waiters it had.
    task automatic test_allocate;
        send_request(csem_pkg::OP_ALLOC, 4'd9, 5'd3, 8'd255);
        send_request(csem_pkg::OP_POST, 4'd0, 5'd3, 8'd0);
        send_request(csem_pkg::OP_WAIT, 4'd0, 5'd3, 8'd0);
        send_request(csem_pkg::OP_WAIT, 4'd2, 5'd7, 8'd0);
        send_request(csem_pkg::OP_ALLOC, 4'd0, 5'd0, 8'd0);
        send_request(csem_pkg::OP_ALLOC, 4'd15, 5'd31, 8'd0);
        send_request(csem_pkg::OP_POST, 4'd2, 5'd0, 8'd0);
        send_request(csem_pkg::OP_WAIT, 4'd2, 5'd1, 8'd0);
    endtask

    // Fill one wait queue to its depth, push one more caller against it, then
    // release the oldest waiter.
    task automatic test_queue_overflow;
        for (int i = 0; i < csem_pkg::WAIT_DEPTH; i++) begin
            send_request(csem_pkg::OP_WAIT, 4'd3, (csem_pkg::PID_W)'(i * 2 + 1),
                         (csem_pkg::CNT_W)'($urandom_range(0, 255)));
        end
        send_request(csem_pkg::OP_WAIT, 4'd3, 5'd30, 8'd0);
        send_request(csem_pkg::OP_POST, 4'd3, 5'd0, 8'd0);
    endtask

    // Random traffic in rounds. Each round concentrates on a few neighboring
    // semaphores so that queues fill and drain, and leans toward waits or posts
    // by a different amount. The first round runs with no idling on either side.
    task automatic test_random_traffic;
        int                          wait_pct[NUM_ROUNDS] = '{50, 85, 30, 70, 15, 90, 50};
        int                          hot_base;
        int                          pick;
        logic [csem_pkg::FUNC_W-1:0] func;
        logic [csem_pkg::SEM_W-1:0]  sid;
        for (int round = 0; round < NUM_ROUNDS; round++) begin
            if (round == 0) begin
                gap_max    = 0;
                stall_mode = STALL_NONE;
            end else begin
                gap_max    = $urandom_range(1, 6);
                stall_mode = (round % 2 == 1) ? STALL_RANDOM : STALL_RUNS;
            end
            hot_base = $urandom_range(0, csem_pkg::NUM_SEMS - 1);
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    func = csem_pkg::OP_ALLOC;
                end else if (pick < 8) begin
                    func = FUNC_NOP;
                end else if ($urandom_range(0, 99) < wait_pct[round]) begin
                    func = csem_pkg::OP_WAIT;
                end else begin
                    func = csem_pkg::OP_POST;
                end
                if ($urandom_range(0, 3) != 0) begin
                    sid = (csem_pkg::SEM_W)'(hot_base + $urandom_range(0, 3));
                end else begin
                    sid = (csem_pkg::SEM_W)'($urandom_range(0, csem_pkg::NUM_SEMS - 1));
                end
                send_request(func, sid, (csem_pkg::PID_W)'($urandom_range(0, 31)),
                             (csem_pkg::CNT_W)'($urandom_range(0, 255)));
            end
        end
    endtask

    // Drain whatever ids remain, then show that further allocations fail.
    task automatic test_pool_exhaustion;
        gap_max    = 3;
        stall_mode = STALL_RUNS;
        while (free_len != 0) begin
            send_request(csem_pkg::OP_ALLOC, (csem_pkg::SEM_W)'($urandom_range(0, 15)), 5'd0,
                         (csem_pkg::CNT_W)'($urandom_range(0, 255)));
        end
        send_request(csem_pkg::OP_ALLOC, 4'd0, 5'd0, 8'd0);
        send_request(csem_pkg::OP_ALLOC, 4'd15, 5'd31, 8'd255);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed tests run with light idling so gaps fall between their steps.
        gap_max    = 2;
        stall_mode = STALL_RANDOM;
        test_wait_post();
        test_allocate();
        test_queue_overflow();
        test_random_traffic();
        test_pool_exhaustion();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests and %0d results: %0d ids granted, %0d refused,",
                 items_sent, results_seen, n_granted, n_nofree);
        $display("%0d callers blocked, %0d woken, %0d queue overflows, %0d saturated posts.",
                 n_blocked, n_woken, n_overflow, n_saturated);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/csem_pkg.sv
src/csem_store.sv
src/csem_exec.sv
src/counting_semaphore_engine.sv
test/tb_counting_semaphore_engine.sv
